[rtl/core/cpm_pkg.sv]
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types and constants of the cartridge protection mapper: access and
// result records, outcome codes, configuration register indexes and the
// fixed slot addresses of the protection layer.
// ----------------------------------------------------------------------------
package cpm_pkg;

  // Field widths
  localparam int unsigned AddrW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 22;
  localparam int unsigned LenW    = 3;
  localparam int unsigned CfgIdxW = 1;

  // Register file sizes
  localparam int unsigned SetupDepth = 11;
  localparam int unsigned SeqDepth   = 4;

  // Protection layer constants
  localparam logic [ByteW-1:0]   KeyByte         = 8'h96;
  localparam logic [AddrW-1:0]   SlotMask        = 16'hF00F;
  localparam logic [AddrW-1:0]   SlotSeq         = 16'h7000;
  localparam logic [AddrW-1:0]   SlotLock        = 16'h700F;
  localparam logic [AddrW-1:0]   SlotFirstUnused = 16'h700B;
  localparam logic [AddrW-1:0]   SlotReplace     = 16'h7008;
  localparam logic [AddrW-1:0]   SlotBank        = 16'h6000;
  localparam logic [AddrW-1:0]   ProtEnd         = 16'h8000;
  localparam logic [AddrW-1:0]   Bank0End        = 16'h4000;
  localparam logic [OffsetW-1:0] OffsetMaskReset = 22'h3FFFFF;

  // Access kind
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Result kind
  typedef enum logic [1:0] {
    OUT_PASS   = 2'd0,
    OUT_SEQ    = 2'd1,
    OUT_REPL   = 2'd2,
    OUT_ABSORB = 2'd3
  } outcome_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED = 1'b0,
    CFG_MASK = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] current_bank;
  } item_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [ByteW-1:0]   read_data;
    logic [OffsetW-1:0] rom_offset;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0]   running_seed;
    logic [OffsetW-1:0] rom_offset_mask;
  } cfg_t;

endpackage

[rtl/core/cart_protection_mapper_unit.sv]
// Path: an access is held in the input register, goes through one pass of logic
// and lands in the result register.
// Throughput: one access per cycle while the result side does not stall; the protection
// state is updated in the same cycle that the result register loads.
// Reset: rst_ni clears all protection state, both stages and the configuration
// (seed zero, offset mask all ones); no clearing pass is needed.
// ----------------------------------------------------------------------------
// cart_protection_mapper_unit
// Top level of the cartridge protection mapper: stream ports, configuration
// registers, input register and result register around the access unit.
// ----------------------------------------------------------------------------
module cart_protection_mapper_unit
  import cpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [OffsetW-1:0] cfg_wdata_i,
  // Access stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // address[15:0], data[23:16], current_bank[31:24]
  input  logic [0:0]         s_axis_tuser,   // op[0]
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // read_data[7:0], rom_offset[29:8], zero[31:30]
  output logic [1:0]         m_axis_tuser    // outcome[1:0]
);

  cfg_t    cfg_q;
  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t res;
  logic    advance;
  logic    s_fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.running_seed    <= '0;
      cfg_q.rom_offset_mask <= OffsetMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEED: cfg_q.running_seed    <= cfg_wdata_i[ByteW-1:0];
        CFG_MASK: cfg_q.rom_offset_mask <= cfg_wdata_i;
        default:  cfg_q <= cfg_q;
      endcase
    end
  end

  // Handshake: move the held access on whenever the result register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.op           <= op_e'(s_axis_tuser[0]);
      in_item_q.address      <= s_axis_tdata[15:0];
      in_item_q.data         <= s_axis_tdata[23:16];
      in_item_q.current_bank <= s_axis_tdata[31:24];
    end
  end

  cpm_access_unit u_access (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.rom_offset, out_res_q.read_data};
  assign m_axis_tuser  = out_res_q.outcome;

endmodule

[rtl/core/cpm_access_unit.sv]
// ----------------------------------------------------------------------------
// cpm_access_unit
// Protection layer state and the single-pass evaluation of one bus access:
// decodes writes into unlock, lock and register file updates, and resolves
// reads into sequence bytes, replaced ROM offsets or pass-through.
// ----------------------------------------------------------------------------
module cpm_access_unit
  import cpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic                   unlocked_q, unlocked_d;
  logic [ByteW-1:0]       running_q, running_d;
  logic [ByteW-1:0]       latch_q, latch_d;
  logic [ByteW-1:0]       setup_q [SetupDepth];
  logic [ByteW-1:0]       setup_d [SetupDepth];
  logic [ByteW-1:0]       seq_bank_q, seq_bank_d;
  logic [AddrW-1:0]       seq_addr_q, seq_addr_d;
  logic [LenW-1:0]        seq_len_q, seq_len_d;
  logic [ByteW-1:0]       seq_bytes_q [SeqDepth];
  logic [ByteW-1:0]       seq_bytes_d [SeqDepth];
  logic [LenW-1:0]        seq_rem_q, seq_rem_d;
  logic                   repl_en_q, repl_en_d;
  logic [AddrW-1:0]       repl_addr_q, repl_addr_d;
  logic [ByteW-1:0]       repl_bank_q, repl_bank_d;

  logic [AddrW-1:0]       slot;
  logic                   in_window;
  logic                   slot_unused;
  logic [ByteW-1:0]       folded;
  logic [2:0]             len_code;
  logic                   in_bank;
  logic [LenW-1:0]        rem_trig;
  logic [LenW-1:0]        rem_next;
  logic [1:0]             seq_idx;
  logic [OffsetW-1:0]     repl_base;

  // Decode the slot and fold the running byte
  assign slot        = item_i.address & SlotMask;
  assign in_window   = (item_i.address >= SlotBank) && (item_i.address < ProtEnd);
  assign slot_unused = (slot >= SlotFirstUnused) || ((slot < SlotSeq) && (slot > SlotBank));
  assign folded      = {running_q[0], running_q[ByteW-1:1]} ^ item_i.data;

  // Read side helpers
  assign in_bank   = ((seq_bank_q == '0) && (item_i.address < Bank0End)) ||
                     ((seq_bank_q == item_i.current_bank) && (item_i.address >= Bank0End));
  assign rem_trig  = (in_bank && (item_i.address == seq_addr_q) && (seq_rem_q == '0)) ?
                     seq_len_q : seq_rem_q;
  assign rem_next  = rem_trig - LenW'(1);
  assign seq_idx   = seq_len_q[1:0] - rem_next[1:0] - 2'd1;
  assign repl_base = {repl_bank_q, 14'b0} & cfg_i.rom_offset_mask;

  // Evaluate one access against the current state
  always_comb begin
    unlocked_d  = unlocked_q;
    running_d   = running_q;
    latch_d     = latch_q;
    setup_d     = setup_q;
    seq_bank_d  = seq_bank_q;
    seq_addr_d  = seq_addr_q;
    seq_len_d   = seq_len_q;
    seq_bytes_d = seq_bytes_q;
    seq_rem_d   = seq_rem_q;
    repl_en_d   = repl_en_q;
    repl_addr_d = repl_addr_q;
    repl_bank_d = repl_bank_q;
    len_code    = '0;
    res_o       = '0;
    res_o.outcome = OUT_PASS;

    if (item_i.op == OP_WRITE) begin
      if (in_window) begin
        res_o.outcome = OUT_ABSORB;
        if ((slot == SlotSeq) && (item_i.data == KeyByte)) begin
          unlocked_d = 1'b1;
          running_d  = cfg_i.running_seed;
        end else if ((slot == SlotLock) && (item_i.data == KeyByte)) begin
          unlocked_d = 1'b0;
        end else if (unlocked_q && !slot_unused) begin
          running_d = folded;
          if (slot >= SlotSeq) begin
            for (int k = 0; k < SetupDepth; k++) begin
              if (slot[3:0] == 4'(k)) begin
                setup_d[k] = folded;
              end
            end
          end else begin
            latch_d = folded;
          end
          // Arm the read sequence
          if (slot == SlotSeq) begin
            seq_bank_d = setup_d[3];
            seq_addr_d = {setup_d[2], setup_d[1]};
            for (int k = 0; k < SeqDepth; k++) begin
              seq_bytes_d[k] = setup_d[4+k];
            end
            len_code  = setup_d[0][2:0];
            seq_len_d = len_code[2] ? (LenW'(len_code[1:0]) + LenW'(1)) : '0;
          end
          // Arm the bank 0 replacement
          if (slot == SlotReplace) begin
            repl_addr_d = {setup_d[10], setup_d[9]};
            repl_bank_d = latch_q;
            repl_en_d   = &setup_d[8][3:0];
          end
        end
      end
    end else begin
      seq_rem_d = rem_trig;
      if ((rem_trig != '0) && (item_i.address < ProtEnd)) begin
        seq_rem_d       = rem_next;
        res_o.outcome   = OUT_SEQ;
        res_o.read_data = seq_bytes_q[seq_idx];
      end else if (repl_en_q && (item_i.address >= repl_addr_q) &&
                   (item_i.address < Bank0End)) begin
        res_o.outcome    = OUT_REPL;
        res_o.rom_offset = repl_base + OffsetW'(item_i.address);
      end
    end
  end

  // Commit the new state when the access is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlocked_q  <= 1'b0;
      running_q   <= '0;
      latch_q     <= '0;
      seq_bank_q  <= '0;
      seq_addr_q  <= '0;
      seq_len_q   <= '0;
      seq_rem_q   <= '0;
      repl_en_q   <= 1'b0;
      repl_addr_q <= '0;
      repl_bank_q <= '0;
      for (int k = 0; k < SetupDepth; k++) begin
        setup_q[k] <= '0;
      end
      for (int k = 0; k < SeqDepth; k++) begin
        seq_bytes_q[k] <= '0;
      end
    end else if (fire_i) begin
      unlocked_q  <= unlocked_d;
      running_q   <= running_d;
      latch_q     <= latch_d;
      seq_bank_q  <= seq_bank_d;
      seq_addr_q  <= seq_addr_d;
      seq_len_q   <= seq_len_d;
      seq_rem_q   <= seq_rem_d;
      repl_en_q   <= repl_en_d;
      repl_addr_q <= repl_addr_d;
      repl_bank_q <= repl_bank_d;
      setup_q     <= setup_d;
      seq_bytes_q <= seq_bytes_d;
    end
  end

`ifndef SYNTHESIS
  // Sequence length never exceeds four bytes
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q <= LenW'(SeqDepth))
    else $error("sequence length out of range");

  // Remaining count never exceeds four bytes
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_rem_q <= LenW'(SeqDepth))
    else $error("sequence remaining count out of range");

  // A write leaves the sequence position untouched
  a_write_keeps_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.op == OP_WRITE) |=> $stable(seq_rem_q))
    else $error("write moved the sequence position");

  // A write is only ever passed or absorbed
  a_write_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.op == OP_WRITE) |->
      (res_o.outcome == OUT_PASS) || (res_o.outcome == OUT_ABSORB))
    else $error("write produced a read outcome");

  // Data fields stay zero outside their own outcome
  a_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> ((res_o.outcome == OUT_SEQ) || (res_o.read_data == '0)) &&
               ((res_o.outcome == OUT_REPL) || (res_o.rom_offset == '0)))
    else $error("result field set outside its outcome");
`endif

endmodule

[bench/cpm_access_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpm_access_checker
// Watches the access and result streams and the register write port of the
// cartridge protection mapper. Predicts each response from its own copy of
// the protection state and compares it field by field.
// ----------------------------------------------------------------------------
module cpm_access_checker
  import cpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [OffsetW-1:0] cfg_wdata_i,
  input  logic               acc_valid_i,
  input  logic               acc_ready_i,
  input  logic [31:0]        acc_data_i,   // address[15:0], data[23:16], current_bank[31:24]
  input  logic [0:0]         acc_user_i,   // op[0]
  input  logic               rsp_valid_i,
  input  logic               rsp_ready_i,
  input  logic [31:0]        rsp_data_i,   // read_data[7:0], rom_offset[29:8], zero[31:30]
  input  logic [1:0]         rsp_user_i,   // outcome[1:0]
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  // Register copies
  logic [ByteW-1:0]   seed_q;
  logic [OffsetW-1:0] mask_q;

  // Protection state
  logic             unlocked;
  logic [ByteW-1:0] running;
  logic [ByteW-1:0] bank_latch;
  logic [ByteW-1:0] setup_file [SetupDepth];
  logic [ByteW-1:0] seq_bank;
  logic [AddrW-1:0] seq_addr;
  logic [LenW-1:0]  seq_len;
  logic [ByteW-1:0] seq_byte [SeqDepth];
  logic [LenW-1:0]  seq_left;
  logic             repl_on;
  logic [AddrW-1:0] repl_addr;
  logic [ByteW-1:0] repl_bank;

  result_t     awaited_responses[$];
  int unsigned mismatches;

  task automatic clear_protection();
    unlocked   = 1'b0;
    running    = '0;
    bank_latch = '0;
    foreach (setup_file[i]) setup_file[i] = '0;
    seq_bank   = '0;
    seq_addr   = '0;
    seq_len    = '0;
    foreach (seq_byte[i]) seq_byte[i] = '0;
    seq_left   = '0;
    repl_on    = 1'b0;
    repl_addr  = '0;
    repl_bank  = '0;
  endtask

  // Apply a write inside the protected window to the protection state
  task automatic absorb_write(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] data);
    logic [AddrW-1:0] slot;
    slot = addr & SlotMask;
    if (slot == SlotSeq && data == KeyByte) begin
      unlocked = 1'b1;
      running  = seed_q;
      return;
    end
    if (slot == SlotLock && data == KeyByte) begin
      unlocked = 1'b0;
      return;
    end
    if (!unlocked) return;
    if (slot >= SlotFirstUnused || (slot < SlotSeq && slot > SlotBank)) return;

    // rotate right, fold in the data, store into the slot
    running = {running[0], running[ByteW-1:1]} ^ data;
    if (slot >= SlotSeq) setup_file[slot[3:0]] = running;
    else bank_latch = running;

    if (slot == SlotSeq) begin
      seq_bank = setup_file[3];
      seq_addr = {setup_file[2], setup_file[1]};
      for (int i = 0; i < SeqDepth; i++) seq_byte[i] = setup_file[4+i];
      seq_len = setup_file[0][2] ? setup_file[0][2:0] - 3'd3 : 3'd0;
    end
    if (slot == SlotReplace) begin
      repl_addr = {setup_file[10], setup_file[9]};
      repl_bank = bank_latch;
      repl_on   = (setup_file[8][3:0] == 4'hF);
    end
  endtask

  // Work out the response to one bus access and advance the state
  task automatic respond(input item_t acc, output result_t rsp);
    logic               hit;
    logic [LenW-1:0]    pos;
    logic [OffsetW-1:0] base;
    rsp.outcome    = OUT_PASS;
    rsp.read_data  = '0;
    rsp.rom_offset = '0;
    if (acc.op == OP_WRITE) begin
      if (acc.address >= SlotBank && acc.address < ProtEnd) begin
        absorb_write(acc.address, acc.data);
        rsp.outcome = OUT_ABSORB;
      end
      return;
    end

    hit = (seq_bank == '0 && acc.address < Bank0End) ||
          (seq_bank == acc.current_bank && acc.address >= Bank0End);
    if (hit && acc.address == seq_addr && seq_left == '0) seq_left = seq_len;

    if (seq_left != '0 && acc.address < ProtEnd) begin
      seq_left      = seq_left - 3'd1;
      pos           = seq_len - seq_left - 3'd1;
      rsp.outcome   = OUT_SEQ;
      rsp.read_data = seq_byte[pos[1:0]];
    end else if (repl_on && acc.address >= repl_addr && acc.address < Bank0End) begin
      base           = {repl_bank, 14'd0} & mask_q;
      rsp.outcome    = OUT_REPL;
      rsp.rom_offset = base + OffsetW'(acc.address);
    end
  endtask

  function automatic int unsigned field_differs(string name, logic [31:0] want,
                                                logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_bus
    item_t   acc;
    result_t want;
    if (!rst_ni) begin
      clear_protection();
      seed_q = '0;
      mask_q = OffsetMaskReset;
      awaited_responses.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // track register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SEED: seed_q = cfg_wdata_i[ByteW-1:0];
          CFG_MASK: mask_q = cfg_wdata_i;
          default: ;
        endcase
      end

      // compare a response transaction with the oldest prediction
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t ns: unexpected response, expected none, actual outcome %0d data 0x%0h",
                   $time, rsp_user_i, rsp_data_i);
          mismatches++;
        end else begin
          want = awaited_responses.pop_front();
          mismatches += field_differs("outcome", want.outcome, rsp_user_i);
          mismatches += field_differs("read_data", want.read_data, rsp_data_i[7:0]);
          mismatches += field_differs("rom_offset", want.rom_offset, rsp_data_i[29:8]);
          mismatches += field_differs("tdata padding", '0, rsp_data_i[31:30]);
        end
      end

      // predict the response to an access transaction
      if (acc_valid_i && acc_ready_i) begin
        acc.op           = op_e'(acc_user_i[0]);
        acc.address      = acc_data_i[15:0];
        acc.data         = acc_data_i[23:16];
        acc.current_bank = acc_data_i[31:24];
        respond(acc, want);
        awaited_responses.push_back(want);
      end

      pending_o <= awaited_responses.size();
      errors_o  <= mismatches;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses into the cartridge protection mapper: a directed pass
// over the unlock, lock, sequence and replacement cases, then programmed
// sequences and replacements mixed with bus noise under four handshake
// phases and four register settings. The checker judges every response.
// ----------------------------------------------------------------------------
module testbench;
  import cpm_pkg::*;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [OffsetW-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;   // address[15:0], data[23:16], current_bank[31:24]
  logic [0:0]         s_axis_tuser  = '0;   // op[0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;         // read_data[7:0], rom_offset[29:8], zero[31:30]
  logic [1:0]         m_axis_tuser;         // outcome[1:0]

  int unsigned pending;
  int unsigned errors;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent      = 0;

  // Stimulus-side guesses of the seed and the running byte
  logic [ByteW-1:0] seed_now      = '0;
  logic [ByteW-1:0] running_guess = '0;

  cart_protection_mapper_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  cpm_access_checker access_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .acc_valid_i (s_axis_tvalid), .acc_ready_i (s_axis_tready),
    .acc_data_i  (s_axis_tdata),  .acc_user_i  (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid), .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),  .rsp_user_i  (m_axis_tuser),
    .pending_o   (pending),       .errors_o    (errors)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Bound the run
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [ByteW-1:0] rotr(logic [ByteW-1:0] v);
    return {v[0], v[ByteW-1:1]};
  endfunction

  // Scatter the don't-care middle bits of a slot address
  function automatic logic [AddrW-1:0] mirror(logic [AddrW-1:0] slot);
    return slot | {4'h0, 8'($urandom), 4'h0};
  endfunction

  // Offer one access transaction, idling first at random
  task automatic send_access(input op_e op, input logic [AddrW-1:0] addr,
                             input logic [ByteW-1:0] data, input logic [ByteW-1:0] bank);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bank, data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_read(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] bank);
    send_access(OP_READ, addr, 8'($urandom), bank);
  endtask

  task automatic unlock();
    send_access(OP_WRITE, mirror(SlotSeq), KeyByte, 8'($urandom));
    running_guess = seed_now;
  endtask

  task automatic lock();
    send_access(OP_WRITE, mirror(SlotLock), KeyByte, 8'($urandom));
  endtask

  // Write a known slot so that the folded value lands as the wanted byte
  task automatic fold_to(input logic [AddrW-1:0] slot, input logic [ByteW-1:0] want);
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] pad;
    data = rotr(running_guess) ^ want;
    while (slot == SlotSeq && data == KeyByte) begin
      // step the running byte through the bank latch so the key is not sent
      pad = 8'($urandom);
      send_access(OP_WRITE, mirror(SlotBank), pad, 8'($urandom));
      running_guess = rotr(running_guess) ^ pad;
      data = rotr(running_guess) ^ want;
    end
    send_access(OP_WRITE, mirror(slot), data, 8'($urandom));
    running_guess = want;
  endtask

  task automatic arm_sequence(input logic [ByteW-1:0] bank, input logic [AddrW-1:0] start,
                              input logic [ByteW-1:0] code);
    unlock();
    fold_to(SlotSeq + 16'd1, start[7:0]);
    fold_to(SlotSeq + 16'd2, start[15:8]);
    fold_to(SlotSeq + 16'd3, bank);
    for (int i = 0; i < SeqDepth; i++) fold_to(SlotSeq + 16'(4 + i), 8'($urandom));
    fold_to(SlotSeq, code);
  endtask

  task automatic arm_replacement(input logic [ByteW-1:0] bank, input logic [AddrW-1:0] start,
                                 input logic [ByteW-1:0] ctrl);
    unlock();
    fold_to(SlotBank, bank);
    fold_to(SlotReplace + 16'd1, start[7:0]);
    fold_to(SlotReplace + 16'd2, start[15:8]);
    fold_to(SlotReplace, ctrl);
  endtask

  // Arm a read sequence, then trigger and drain it amid other reads
  task automatic sequence_episode();
    logic [ByteW-1:0] bank;
    logic [AddrW-1:0] start;
    logic [ByteW-1:0] code;
    int unsigned      reads;
    bank  = ($urandom_range(1)) ? 8'h00 : 8'($urandom);
    start = (bank == 8'h00) ? 16'($urandom_range(16'h3FFF)) :
                              16'($urandom_range(16'h7FFF, 16'h4000));
    if ($urandom_range(9) == 0) start = 16'($urandom);
    code  = 8'($urandom);
    if ($urandom_range(9) < 8) code[2] = 1'b1;
    arm_sequence(bank, start, code);
    if ($urandom_range(1)) lock();

    // trigger, usually from the matching bank
    send_read(start, ($urandom_range(9) < 8) ? bank : 8'($urandom));
    reads = $urandom_range(7, 2);
    repeat (reads) begin
      case ($urandom_range(9))
        0: send_read(16'($urandom_range(16'hFFFF, 16'h8000)), 8'($urandom));
        1: send_read(start, bank);
        2: fold_to(SlotSeq, 8'($urandom));   // change the length mid-sequence
        default: send_read(16'($urandom_range(16'h7FFF)), 8'($urandom));
      endcase
    end
  endtask

  // Arm a bank-0 replacement and read around it
  task automatic replacement_episode();
    logic [AddrW-1:0] start;
    logic [ByteW-1:0] ctrl;
    start = ($urandom_range(9) < 8) ? 16'($urandom_range(16'h3FFF)) : 16'($urandom);
    ctrl  = 8'($urandom);
    if ($urandom_range(3) != 0) ctrl[3:0] = 4'hF;
    arm_replacement(8'($urandom), start, ctrl);
    if ($urandom_range(1)) lock();
    repeat ($urandom_range(8, 3)) begin
      if ($urandom_range(9) < 7) send_read(16'($urandom_range(16'h3FFF)), 8'($urandom));
      else send_read(16'($urandom), 8'($urandom));
    end
  endtask

  // Random accesses, biased toward the protected window and the key slots
  task automatic noise_episode();
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    repeat ($urandom_range(10, 5)) begin
      data = ($urandom_range(9) == 0) ? KeyByte : 8'($urandom);
      case ($urandom_range(3))
        0: addr = 16'($urandom);
        1: addr = 16'($urandom_range(16'h7FFF, 16'h6000));
        2: addr = mirror(($urandom_range(1)) ? SlotSeq : SlotLock);
        default: addr = mirror(SlotBank | 16'($urandom_range(15)));
      endcase
      send_access(op_e'($urandom_range(1)), addr, data, 8'($urandom));
    end
  endtask

  // Drop valid and wait until every response is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [ByteW-1:0] seed, input logic [OffsetW-1:0] mask);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SEED;
    cfg_wdata_i <= OffsetW'(seed);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MASK;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_now = seed;
  endtask

  initial begin
    logic [ByteW-1:0]   seeds   [4];
    logic [OffsetW-1:0] masks   [4];
    int unsigned        idles   [4];
    int unsigned        stalls  [4];
    int unsigned        target;
    seeds  = '{8'h00, 8'hFF, 8'($urandom), 8'h5A};
    masks  = '{OffsetMaskReset, 22'h0, 22'($urandom), 22'h3FC000};
    idles  = '{0, 56, 0, 33};
    stalls = '{0, 0, 56, 33};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass under reset settings
    send_read(16'h0000, 8'h00);
    send_access(OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
    send_access(OP_WRITE, SlotBank - 16'd1, 8'hFF, 8'h00);   // below the window
    send_access(OP_WRITE, ProtEnd, 8'h00, 8'hFF);            // above the window
    send_access(OP_WRITE, SlotSeq + 16'd5, 8'h55, 8'h00);    // absorbed while locked
    lock();                                                  // lock while locked
    unlock();
    unlock();                                                // reload while unlocked
    send_access(OP_WRITE, SlotBank + 16'd5, 8'hAA, 8'h00);   // unknown slots
    send_access(OP_WRITE, SlotFirstUnused, 8'h12, 8'h00);
    send_access(OP_WRITE, SlotLock, 8'h00, 8'h00);
    arm_sequence(8'h00, 16'h1234, 8'h07);
    send_read(16'h1234, 8'h00);
    send_read(ProtEnd, 8'h00);                               // outside, not consumed
    send_read(16'h0001, 8'h00);
    fold_to(SlotSeq, 8'h04);                                 // shorten mid-sequence
    send_read(16'h0002, 8'h00);
    arm_replacement(8'hFF, 16'h0000, 8'h0F);
    send_read(Bank0End - 16'd1, 8'h00);
    send_read(Bank0End, 8'h00);
    lock();
    send_read(16'h0100, 8'h00);

    // Random phases, each with its own handshake pressure and settings
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      load_settings(seeds[ph], masks[ph]);
      idle_pct  = idles[ph];
      stall_pct = stalls[ph];
      target    = sent + 372;
      while (sent < target) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: sequence_episode();
          9, 10, 11, 12, 13:         replacement_episode();
          default:                   noise_episode();
        endcase
      end
    end

    stall_pct = 0;
    drain();

    $display("Drove %0d accesses: directed cases, programmed sequences and replacements,",
             sent);
    $display("bus noise; four handshake phases and four seed/mask settings.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
